// ----- rtl/h2s_pkg.sv -----
// shared types, constants and lookup tables for the hid to scancode translator
// no dependencies
`default_nettype none

package h2s_pkg;

    localparam int KEY_W = 8;
    localparam int MOD_W = 8;
    localparam int CODE_W = 8;
    localparam int DEV_W = 2;

    // device type codes
    localparam logic [DEV_W-1:0] DEV_NONE     = 2'd0;
    localparam logic [DEV_W-1:0] DEV_KEYBOARD = 2'd1;
    localparam logic [DEV_W-1:0] DEV_MOUSE    = 2'd2;
    localparam logic [DEV_W-1:0] DEV_PAD      = 2'd3;

    localparam logic [CODE_W-1:0] BREAK_FLAG = 8'h80;

    // modifier bits that have a scancode (gui keys have none)
    localparam logic [MOD_W-1:0] MOD_EMIT_MASK = 8'b0111_0111;

    localparam logic [CODE_W-1:0] MOD_CODE [0:MOD_W-1] = '{
        8'h1d, 8'h2a, 8'h38, 8'h00, 8'h1d, 8'h36, 8'h38, 8'h00
    };

    // lower half of the usage table, upper half maps to zero
    localparam logic [CODE_W-1:0] USAGE_MAP [0:127] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h1e, 8'h30, 8'h2e, 8'h20,
        8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
        8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1f, 8'h14,
        8'h16, 8'h2f, 8'h11, 8'h2d, 8'h15, 8'h2c, 8'h02, 8'h03,
        8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b,
        8'h1c, 8'h01, 8'h0e, 8'h0f, 8'h39, 8'h0c, 8'h0d, 8'h1a,
        8'h1b, 8'h2b, 8'h2b, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
        8'h35, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h52, 8'h47, 8'h00, 8'h53, 8'h00, 8'h00, 8'h4d, 8'h4b,
        8'h50, 8'h48, 8'h00, 8'h64, 8'h65, 8'h4a, 8'h4e, 8'h72,
        8'h6d, 8'h6e, 8'h6f, 8'h6a, 8'h6b, 8'h6c, 8'h67, 8'h68,
        8'h69, 8'h70, 8'h71, 8'h00, 8'h60, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h62, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // pending work for one report, handed from the front end to the emitter
    typedef struct packed {
        logic             key_pend;
        logic             key_brk;
        logic [MOD_W-1:0] mod_pend;
        logic [MOD_W-1:0] mods;
    } h2s_work_t;

    function automatic logic [CODE_W-1:0] usage_lookup(input logic [KEY_W-1:0] usage);
        logic [CODE_W-1:0] code;
        code = usage[KEY_W-1] ? '0 : USAGE_MAP[usage[KEY_W-2:0]];
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/h2s_usage_rom.sv -----
// synchronous usage-to-scancode rom, registered read
// depends on h2s_pkg for the table contents
`default_nettype none

module h2s_usage_rom
    import h2s_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [KEY_W-1:0]  rd_addr,
    output logic      [CODE_W-1:0] rd_data
);

    logic [CODE_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_reg <= usage_lookup(rd_addr);
        end
    end

    assign rd_data = data_reg;

endmodule

`default_nettype wire

// ----- rtl/h2s_state_mem.sv -----
// one-entry state memory holding the last key usage and modifier bitmap
// registered read with write-first forwarding; depends on h2s_pkg
`default_nettype none

module h2s_state_mem
    import h2s_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   wr_en,
    input  wire logic [KEY_W+MOD_W-1:0] wr_data,
    output logic      [KEY_W+MOD_W-1:0] rd_data
);

    logic [KEY_W+MOD_W-1:0] mem [0:0];
    logic [KEY_W+MOD_W-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem[0] <= '0;
        end else if (wr_en) begin
            mem[0] <= wr_data;
        end
    end

    // read every cycle so a waiting report always sees the latest write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= '0;
        end else begin
            rd_reg <= wr_en ? wr_data : mem[0];
        end
    end

    assign rd_data = rd_reg;

`ifndef SYNTHESIS
    a_write_forwarded: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> rd_data == $past(wr_data))
        else $error("state write not visible on next read");
`endif

endmodule

`default_nettype wire

// ----- rtl/h2s_emitter.sv -----
// serializes the pending scancodes of one report onto the output register
// key code first, then modifiers from bit 0 up; depends on h2s_pkg
`default_nettype none

module h2s_emitter
    import h2s_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load_work,
    input  wire h2s_work_t         work_in,
    input  wire logic [CODE_W-1:0] key_code,
    output logic                   em_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [CODE_W-1:0] m_code,
    output logic                   m_last
);

    h2s_work_t         work_reg, work_next;
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic              out_last_reg, out_last_next;

    logic              work_any;
    logic              out_load;
    logic [2:0]        sel;
    logic [MOD_W-1:0]  mod_rest;
    logic [CODE_W-1:0] pick_code;
    logic              pick_last;

    assign work_any = work_reg.key_pend || (work_reg.mod_pend != '0);
    assign out_load = work_any && (!out_valid_reg || m_ready);

    always_comb begin
        sel = '0;
        for (int i = MOD_W - 1; i >= 0; i--) begin
            if (work_reg.mod_pend[i]) begin
                sel = 3'(i);
            end
        end
    end

    // clears the lowest pending modifier
    assign mod_rest = work_reg.mod_pend & (work_reg.mod_pend - 8'd1);

    always_comb begin
        if (work_reg.key_pend) begin
            pick_code = work_reg.key_brk ? (key_code | BREAK_FLAG) : key_code;
            pick_last = (work_reg.mod_pend == '0);
        end else begin
            pick_code = work_reg.mods[sel] ? MOD_CODE[sel] : (MOD_CODE[sel] | BREAK_FLAG);
            pick_last = (mod_rest == '0);
        end
    end

    assign em_ready = !work_any || (out_load && pick_last);

    always_comb begin
        work_next = work_reg;
        if (out_load) begin
            if (work_reg.key_pend) begin
                work_next.key_pend = 1'b0;
            end else begin
                work_next.mod_pend = mod_rest;
            end
        end
        if (load_work) begin
            work_next = work_in;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_last_next  = out_last_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_code_next  = pick_code;
            out_last_next  = pick_last;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            work_reg      <= work_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_code_reg <= out_code_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid = out_valid_reg;
    assign m_code  = out_code_reg;
    assign m_last  = out_last_reg;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_work |-> em_ready)
        else $error("work loaded while previous report still pending");

    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && pick_last && !load_work |=> !work_any)
        else $error("work left pending after last code");

    a_load_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        load_work |=> work_any)
        else $error("loaded report carries no codes");
`endif

endmodule

`default_nettype wire

// ----- rtl/hid_to_scancode_translator.sv -----
// top level: front end compares each report against the state memory
// uses h2s_pkg, h2s_state_mem, h2s_usage_rom and h2s_emitter
`default_nettype none

// Translates keyboard reports into scancodes, one scancode per cycle on the
// m_ side while m_tready is high, with m_tlast on the final code of a report.
// In the front stage a report is compared against the held key and modifier
// state and the usage rom is read; the first code goes via the rom and work
// registers to the output register. A report with n codes (at most seven)
// holds the emitter until its last code is loaded, while the next report with
// codes waits in the front stage; one with no code (no change, not keyboard)
// never waits. State update (keyboard only) and rom read (codes only) happen
// as a report leaves, so back-to-back reports see each other's updates.
module hid_to_scancode_translator
    import h2s_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [7:0] modifier_bits, [15:8] key_usage
    input  wire logic [1:0]  s_tuser,  // [1:0] device_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // [7:0] scancode
    output logic             m_tlast   // last_of_run
);

    logic              a_valid_reg;
    logic [DEV_W-1:0]  a_dev_reg;
    logic [MOD_W-1:0]  a_mods_reg;
    logic [KEY_W-1:0]  a_key_reg;

    logic [KEY_W+MOD_W-1:0] st_rd;
    logic [KEY_W-1:0]  held_key;
    logic [MOD_W-1:0]  held_mods;

    logic              is_kbd;
    logic              key_chg;
    logic [MOD_W-1:0]  mod_chg;
    logic              has_pend;
    logic              a_adv;
    logic              load_work;
    logic              em_ready;
    logic [KEY_W-1:0]  rom_addr;
    logic [CODE_W-1:0] rom_data;
    h2s_work_t         work;

    assign held_key  = st_rd[KEY_W-1:0];
    assign held_mods = st_rd[KEY_W+MOD_W-1:KEY_W];

    assign is_kbd   = (a_dev_reg == DEV_KEYBOARD);
    assign key_chg  = is_kbd && (a_key_reg != held_key);
    assign mod_chg  = is_kbd ? ((a_mods_reg ^ held_mods) & MOD_EMIT_MASK) : '0;
    assign has_pend = key_chg || (mod_chg != '0);

    // a report with nothing to emit never waits for the emitter
    assign a_adv     = a_valid_reg && (!has_pend || em_ready);
    assign load_work = a_adv && has_pend;
    assign s_tready  = !a_valid_reg || a_adv;

    // a release looks up the previously held key
    assign rom_addr = (a_key_reg != '0) ? a_key_reg : held_key;

    assign work.key_pend = key_chg;
    assign work.key_brk  = (a_key_reg == '0);
    assign work.mod_pend = mod_chg;
    assign work.mods     = a_mods_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_dev_reg  <= s_tuser;
            a_mods_reg <= s_tdata[MOD_W-1:0];
            a_key_reg  <= s_tdata[KEY_W+MOD_W-1:MOD_W];
        end
    end

    h2s_state_mem u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (a_adv && is_kbd),
        .wr_data ({a_mods_reg, a_key_reg}),
        .rd_data (st_rd)
    );

    h2s_usage_rom u_rom (
        .aclk    (aclk),
        .rd_en   (load_work),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    h2s_emitter u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_work (load_work),
        .work_in   (work),
        .key_code  (rom_data),
        .em_ready  (em_ready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_code    (m_tdata),
        .m_last    (m_tlast)
    );

`ifndef SYNTHESIS
    a_nonkbd_no_work: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !is_kbd |-> !load_work && a_adv)
        else $error("non-keyboard report produced work or stalled");

    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !a_adv |=> a_valid_reg && $stable(a_key_reg) && $stable(a_mods_reg))
        else $error("front stage lost a waiting report");
`endif

endmodule

`default_nettype wire

// ----- dv/hid_to_scancode_translator_tb.sv -----
// self-checking testbench for hid_to_scancode_translator: directed reports, then random ones
// depends on h2s_pkg and the rtl top level; holds its own scancode predictor

module hid_to_scancode_translator_tb
    import h2s_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;
    localparam int DIR_ROWS    = 24;

    localparam logic [7:0] RELEASE_BIT = 8'h80;

    // ikbd codes for usages 0..127, everything above has no equivalent
    localparam logic [7:0] IKBD_CODE [0:127] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h1e, 8'h30, 8'h2e, 8'h20,
        8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
        8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1f, 8'h14,
        8'h16, 8'h2f, 8'h11, 8'h2d, 8'h15, 8'h2c, 8'h02, 8'h03,
        8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b,
        8'h1c, 8'h01, 8'h0e, 8'h0f, 8'h39, 8'h0c, 8'h0d, 8'h1a,
        8'h1b, 8'h2b, 8'h2b, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
        8'h35, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h52, 8'h47, 8'h00, 8'h53, 8'h00, 8'h00, 8'h4d, 8'h4b,
        8'h50, 8'h48, 8'h00, 8'h64, 8'h65, 8'h4a, 8'h4e, 8'h72,
        8'h6d, 8'h6e, 8'h6f, 8'h6a, 8'h6b, 8'h6c, 8'h67, 8'h68,
        8'h69, 8'h70, 8'h71, 8'h00, 8'h60, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h62, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // lctrl, lshift, lalt, lgui, rctrl, rshift, ralt, rgui
    localparam logic [7:0] MOD_SCANCODE [0:7] = '{
        8'h1d, 8'h2a, 8'h38, 8'h00, 8'h1d, 8'h36, 8'h38, 8'h00
    };

    typedef struct packed {
        logic [7:0] scancode;
        logic       last;
    } scan_item_t;

    typedef struct packed {
        logic [1:0]      dev;
        logic [7:0]      mods;
        logic [7:0]      key;
        logic            typed;
        logic [3:0]      n_codes;
        logic [0:6][7:0] codes;
    } report_row_t;

    // dev, modifiers, key, typed, count, codes in output order
    localparam report_row_t DIRECTED_REPORTS [0:DIR_ROWS-1] = '{
        '{DEV_KEYBOARD, 8'h00, 8'h04, 1'b1, 4'd1, {8'h1e, 48'h0}},
        '{DEV_KEYBOARD, 8'h00, 8'h04, 1'b1, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h00, 8'h00, 1'b1, 4'd1, {8'h9e, 48'h0}},
        '{DEV_KEYBOARD, 8'hff, 8'hff, 1'b1, 4'd7,
          {8'h00, 8'h1d, 8'h2a, 8'h38, 8'h1d, 8'h36, 8'h38}},
        '{DEV_KEYBOARD, 8'h00, 8'h00, 1'b1, 4'd7,
          {8'h80, 8'h9d, 8'haa, 8'hb8, 8'h9d, 8'hb6, 8'hb8}},
        '{DEV_MOUSE,    8'hff, 8'h05, 1'b1, 4'd0, '0},
        '{DEV_PAD,      8'hff, 8'h05, 1'b1, 4'd0, '0},
        '{DEV_NONE,     8'hff, 8'h05, 1'b1, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h08, 8'h00, 1'b1, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h88, 8'h00, 1'b1, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h00, 8'h00, 1'b1, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h00, 8'h05, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h00, 8'h06, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h00, 8'h80, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h00, 8'h00, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h00, 8'h7a, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h00, 8'h7f, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h01, 8'h2c, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h23, 8'h2c, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h44, 8'h00, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'haa, 8'h55, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h55, 8'haa, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h00, 8'h01, 1'b0, 4'd0, '0},
        '{DEV_KEYBOARD, 8'h00, 8'h00, 1'b0, 4'd0, '0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // [7:0] modifier_bits, [15:8] key_usage
    logic [1:0]  s_tuser  = '0;  // [1:0] device_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] scancode
    logic        m_tlast;

    scan_item_t  expected_codes [$];
    scan_item_t  report_codes [$];
    logic [7:0]  kb_key  = '0;
    logic [7:0]  kb_mods = '0;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_off_req   = 1'b0;
    logic        hold_done;
    int          hold_left;
    int          mismatches     = 0;
    int          quiet_cycles;

    always #5ns aclk = ~aclk;

    hid_to_scancode_translator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    function automatic logic [7:0] ikbd_code(input logic [7:0] usage);
        return usage[7] ? 8'h00 : IKBD_CODE[usage[6:0]];
    endfunction

    // scancodes caused by one report, left in report_codes; updates held state
    task automatic translate_report(input logic [1:0] dev, input logic [7:0] mods,
                                    input logic [7:0] key);
        logic [7:0] changed;
        logic [7:0] code;
        scan_item_t item;
        report_codes.delete();
        if (dev == DEV_KEYBOARD) begin
            if (key != kb_key) begin
                // a zero usage releases whatever key was held
                code = (key != 8'h00) ? ikbd_code(key) : (ikbd_code(kb_key) | RELEASE_BIT);
                report_codes.push_back('{code, 1'b0});
                kb_key = key;
            end
            changed = mods ^ kb_mods;
            for (int b = 0; b < 8; b++) begin
                if (changed[b] && MOD_SCANCODE[b] != 8'h00) begin
                    code = mods[b] ? MOD_SCANCODE[b] : (MOD_SCANCODE[b] | RELEASE_BIT);
                    report_codes.push_back('{code, 1'b0});
                end
            end
            kb_mods = mods;
            if (report_codes.size() > 0) begin
                item = report_codes.pop_back();
                item.last = 1'b1;
                report_codes.push_back(item);
            end
        end
    endtask

    task automatic send_report(input report_row_t row);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row.key, row.mods};
        s_tuser  <= row.dev;
        do @(posedge aclk); while (!s_tready);
        translate_report(row.dev, row.mods, row.key);
        if (row.typed) begin
            for (int i = 0; i < row.n_codes; i++)
                expected_codes.push_back('{row.codes[i], i == row.n_codes - 1});
        end else begin
            while (report_codes.size() > 0)
                expected_codes.push_back(report_codes.pop_front());
        end
    endtask

    // mostly keyboard reports that press, repeat, release and flip modifiers
    task automatic run_random(input int kb_reports, input int send_pct, input int recv_pct);
        int          kb_sent;
        int          pick;
        report_row_t row;
        kb_sent = 0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (kb_sent < kb_reports) begin
            row = '0;
            pick = $urandom_range(99);
            if (pick < 85) begin
                row.dev = DEV_KEYBOARD;
            end else begin
                pick = $urandom_range(2);
                row.dev = (pick == 0) ? DEV_NONE : (pick == 1) ? DEV_MOUSE : DEV_PAD;
            end
            pick = $urandom_range(99);
            if (pick < 30)
                row.key = 8'h00;
            else if (pick < 50)
                row.key = kb_key;
            else if (pick < 90)
                row.key = 8'($urandom_range(8'h73, 8'h04));
            else
                row.key = 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 50)
                row.mods = kb_mods ^ (8'h01 << $urandom_range(7));
            else if (pick < 70)
                row.mods = kb_mods;
            else
                row.mods = 8'($urandom_range(255));
            if (row.dev == DEV_KEYBOARD)
                kb_sent++;
            send_report(row);
        end
    endtask

    // receiver side: random stalls, plus one long hold-off counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_off_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        scan_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_codes.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected scancode transfer: code %02h last %0b", m_tdata, m_tlast);
                mismatches <= mismatches + 1;
            end else begin
                want = expected_codes.pop_front();
                if (m_tdata !== want.scancode || m_tlast !== want.last) begin
                    if (mismatches < MAX_REPORTS)
                        $display({"scancode mismatch: expected code %02h last %0b, ",
                                  "got code %02h last %0b"},
                                 want.scancode, want.last, m_tdata, m_tlast);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_report(DIRECTED_REPORTS[r]);

        run_random(60, 0, 0);
        run_random(60, 75, 0);
        run_random(60, 0, 75);
        run_random(60, 26, 26);

        // receiver holds off while reports keep coming, so the input backs up
        hold_off_req <= 1'b1;
        run_random(30, 0, 0);

        // sender pauses until the block has drained
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_codes.size() != 0) @(posedge aclk);

        run_random(35, 26, 26);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
